>>> src/wfc_pkg.sv
package wfc_pkg;

   // Frame length handling
   localparam int MAX_FRAME_BYTES = 4095;
   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W = 12;
   localparam int LEN_OUT_MAX = (1 << LEN_W) - 1;
   localparam int HDR_BASE = 24;
   localparam int WIN_LEN = 16;
   localparam int WIN_IDX_W = $clog2(WIN_LEN);

   // Statistics counters
   localparam int COUNTER_BITS = 32;
   localparam int TOTAL_W = 32;

   // Configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SNIFF_ENABLE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_DATA_FRAMES = CSR_INDEX_W'(1);

   // Frame types from frame control bits 3..2
   localparam logic [1:0] FTYPE_MGMT = 2'd0;
   localparam logic [1:0] FTYPE_CTRL = 2'd1;
   localparam logic [1:0] FTYPE_DATA = 2'd2;
   localparam logic [1:0] FTYPE_RSVD = 2'd3;

   // Management subtypes
   localparam logic [3:0] SUB_PROBE_REQ = 4'h4;
   localparam logic [3:0] SUB_DISASSOC = 4'hA;
   localparam logic [3:0] SUB_DEAUTH = 4'hC;

   // LLC/SNAP and EAPOL ethertype bytes
   localparam logic [7:0] LLC_SNAP_BYTE = 8'hAA;
   localparam logic [7:0] LLC_UI_BYTE = 8'h03;
   localparam logic [7:0] ETYPE_HI_BYTE = 8'h88;
   localparam logic [7:0] ETYPE_LO_BYTE = 8'h8E;

   // Result classes
   localparam logic [2:0] CLASS_MGMT = 3'd0;
   localparam logic [2:0] CLASS_CTRL = 3'd1;
   localparam logic [2:0] CLASS_DATA = 3'd2;
   localparam logic [2:0] CLASS_RSVD = 3'd3;
   localparam logic [2:0] CLASS_EAPOL = 3'd4;
   localparam logic [2:0] CLASS_DEAUTH = 3'd5;
   localparam logic [2:0] CLASS_DISASSOC = 3'd6;
   localparam logic [2:0] CLASS_PROBE = 3'd7;

   typedef struct packed {
      logic [7:0]        rx_byte;
      logic              last_byte;
      logic [3:0]        rx_channel;
      logic signed [7:0] rx_rssi;
   } req_type;

   typedef struct packed {
      logic [2:0]         frame_class;
      logic               report;
      logic [3:0]         frame_channel;
      logic signed [7:0]  frame_rssi;
      logic [47:0]        source_addr;
      logic [47:0]        dest_addr;
      logic [47:0]        bssid_addr;
      logic [LEN_W-1:0]   frame_length;
      logic [TOTAL_W-1:0] type_total;
      logic [TOTAL_W-1:0] event_total;
   } rsp_type;

   // Captured frame handed from the byte capture to the classifier
   typedef struct packed {
      logic                         valid;
      logic [15:0]                  frame_control;
      logic [47:0]                  addr1;
      logic [47:0]                  addr2;
      logic [47:0]                  addr3;
      logic [WIN_LEN-1:0][7:0]      window;
      logic [3:0]                   channel;
      logic signed [7:0]            rssi;
      logic [POS_W-1:0]             length;
   } frame_type;

endpackage

>>> src/wfc_capture.sv
module wfc_capture (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  wfc_pkg::req_type  req,
   input  logic              sniff_enable,
   input  logic              take,
   output wfc_pkg::frame_type frame
);

   logic [wfc_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [wfc_pkg::POS_W-1:0]          len_now;
   logic [wfc_pkg::POS_W-1:0]          len_ff;
   logic                               end_valid_ff, end_valid_in;
   logic [15:0]                        fc_ff;
   logic [47:0]                        addr1_ff, addr2_ff, addr3_ff;
   logic [wfc_pkg::WIN_LEN-1:0][7:0]   win_ff;
   logic [3:0]                         chan_ff;
   logic signed [7:0]                  rssi_ff;
   logic [wfc_pkg::WIN_IDX_W-1:0]      win_off;
   logic                               frame_ok;

   // Count bytes, saturating at the maximum frame size
   always_comb begin
      if (pos_ff == wfc_pkg::POS_W'(wfc_pkg::MAX_FRAME_BYTES)) begin
         len_now = pos_ff;
      end else begin
         len_now = pos_ff + wfc_pkg::POS_W'(1);
      end
      pos_in = req.last_byte ? '0 : len_now;
      win_off = wfc_pkg::WIN_IDX_W'(pos_ff - wfc_pkg::POS_W'(wfc_pkg::HDR_BASE));
      frame_ok = req.last_byte && sniff_enable &&
                 (len_now >= wfc_pkg::POS_W'(wfc_pkg::HDR_BASE));
      end_valid_in = (end_valid_ff && !take) || (accept && frame_ok);
   end

   // Track position and pending frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         end_valid_ff <= 1'b0;
      end else begin
         end_valid_ff <= end_valid_in;
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   // Capture header fields and the payload window
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req.last_byte) begin
            len_ff <= len_now;
         end
         if (pos_ff == '0) begin
            chan_ff <= req.rx_channel;
            rssi_ff <= req.rx_rssi;
            fc_ff[7:0] <= req.rx_byte;
         end else if (pos_ff == wfc_pkg::POS_W'(1)) begin
            fc_ff[15:8] <= req.rx_byte;
         end else if (pos_ff >= wfc_pkg::POS_W'(4) && pos_ff < wfc_pkg::POS_W'(10)) begin
            addr1_ff <= {addr1_ff[39:0], req.rx_byte};
         end else if (pos_ff >= wfc_pkg::POS_W'(10) && pos_ff < wfc_pkg::POS_W'(16)) begin
            addr2_ff <= {addr2_ff[39:0], req.rx_byte};
         end else if (pos_ff >= wfc_pkg::POS_W'(16) && pos_ff < wfc_pkg::POS_W'(22)) begin
            addr3_ff <= {addr3_ff[39:0], req.rx_byte};
         end else if (pos_ff >= wfc_pkg::POS_W'(wfc_pkg::HDR_BASE) &&
                      pos_ff < wfc_pkg::POS_W'(wfc_pkg::HDR_BASE + wfc_pkg::WIN_LEN)) begin
            win_ff[win_off] <= req.rx_byte;
         end
      end
   end

   assign frame.valid = end_valid_ff;
   assign frame.frame_control = fc_ff;
   assign frame.addr1 = addr1_ff;
   assign frame.addr2 = addr2_ff;
   assign frame.addr3 = addr3_ff;
   assign frame.window = win_ff;
   assign frame.channel = chan_ff;
   assign frame.rssi = rssi_ff;
   assign frame.length = len_ff;

endmodule

>>> src/wfc_classify.sv
module wfc_classify (
   input  logic               clock,
   input  logic               reset,
   input  wfc_pkg::frame_type frame,
   input  logic               show_data_frames,
   input  logic               rsp_ready,
   output logic               take,
   output logic               rsp_valid,
   output wfc_pkg::rsp_type   rsp
);

   localparam int CW = wfc_pkg::COUNTER_BITS;

   logic [CW-1:0]   cnt_mgmt_ff, cnt_ctrl_ff, cnt_data_ff;
   logic [CW-1:0]   cnt_eapol_ff, cnt_deauth_ff, cnt_probe_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   wfc_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0]      ftype;
   logic [3:0]      sub;
   logic            qos, four_addr;
   logic [3:0]      hdr_extra;
   logic            long_enough;
   logic            m0, m2, m6, m8, pattern_hit;
   logic            is_eapol, is_deauth_dis, is_probe;
   logic [CW-1:0]   type_next, event_next;
   logic [2:0]      cls;

   // Check LLC/SNAP header and EAPOL ethertype at a fixed window offset
   function automatic logic snap_at(input logic [wfc_pkg::WIN_LEN-1:0][7:0] w,
                                    input logic [wfc_pkg::WIN_IDX_W-1:0] base);
      snap_at = (w[base] == wfc_pkg::LLC_SNAP_BYTE) &&
                (w[base + wfc_pkg::WIN_IDX_W'(1)] == wfc_pkg::LLC_SNAP_BYTE) &&
                (w[base + wfc_pkg::WIN_IDX_W'(2)] == wfc_pkg::LLC_UI_BYTE) &&
                (w[base + wfc_pkg::WIN_IDX_W'(6)] == wfc_pkg::ETYPE_HI_BYTE) &&
                (w[base + wfc_pkg::WIN_IDX_W'(7)] == wfc_pkg::ETYPE_LO_BYTE);
   endfunction

   assign take = frame.valid && (!rsp_valid_ff || rsp_ready);

   // Classify the captured frame
   always_comb begin
      ftype = frame.frame_control[3:2];
      sub = frame.frame_control[7:4];
      qos = sub[3];
      four_addr = (frame.frame_control[9:8] == 2'b11);
      hdr_extra = (qos ? 4'd2 : 4'd0) + (four_addr ? 4'd6 : 4'd0);
      long_enough = (32'(frame.length) >=
                     32'(wfc_pkg::HDR_BASE + 8) + 32'(hdr_extra));
      m0 = snap_at(frame.window, wfc_pkg::WIN_IDX_W'(0));
      m2 = snap_at(frame.window, wfc_pkg::WIN_IDX_W'(2));
      m6 = snap_at(frame.window, wfc_pkg::WIN_IDX_W'(6));
      m8 = snap_at(frame.window, wfc_pkg::WIN_IDX_W'(8));
      unique case ({four_addr, qos})
         2'b00: pattern_hit = m0;
         2'b01: pattern_hit = m2;
         2'b10: pattern_hit = m6;
         default: pattern_hit = m8;
      endcase
      is_eapol = (ftype == wfc_pkg::FTYPE_DATA) && long_enough && pattern_hit;
      is_deauth_dis = (ftype == wfc_pkg::FTYPE_MGMT) &&
                      (sub == wfc_pkg::SUB_DEAUTH || sub == wfc_pkg::SUB_DISASSOC);
      is_probe = (ftype == wfc_pkg::FTYPE_MGMT) && (sub == wfc_pkg::SUB_PROBE_REQ);

      unique case (ftype)
         wfc_pkg::FTYPE_MGMT: type_next = cnt_mgmt_ff + CW'(1);
         wfc_pkg::FTYPE_CTRL: type_next = cnt_ctrl_ff + CW'(1);
         wfc_pkg::FTYPE_DATA: type_next = cnt_data_ff + CW'(1);
         default: type_next = '0;
      endcase

      priority if (is_eapol) begin
         cls = wfc_pkg::CLASS_EAPOL;
         event_next = cnt_eapol_ff + CW'(1);
      end else if (is_deauth_dis) begin
         cls = (sub == wfc_pkg::SUB_DEAUTH) ? wfc_pkg::CLASS_DEAUTH
                                            : wfc_pkg::CLASS_DISASSOC;
         event_next = cnt_deauth_ff + CW'(1);
      end else if (is_probe) begin
         cls = wfc_pkg::CLASS_PROBE;
         event_next = cnt_probe_ff + CW'(1);
      end else begin
         unique case (ftype)
            wfc_pkg::FTYPE_MGMT: cls = wfc_pkg::CLASS_MGMT;
            wfc_pkg::FTYPE_CTRL: cls = wfc_pkg::CLASS_CTRL;
            wfc_pkg::FTYPE_DATA: cls = wfc_pkg::CLASS_DATA;
            default: cls = wfc_pkg::CLASS_RSVD;
         endcase
         event_next = '0;
      end

      rsp_in.frame_class = cls;
      rsp_in.report = is_eapol || is_deauth_dis || is_probe ||
                      (cls == wfc_pkg::CLASS_DATA && show_data_frames);
      rsp_in.frame_channel = frame.channel;
      rsp_in.frame_rssi = frame.rssi;
      rsp_in.source_addr = frame.addr2;
      rsp_in.dest_addr = frame.addr1;
      rsp_in.bssid_addr = frame.addr3;
      if (32'(frame.length) > 32'(wfc_pkg::LEN_OUT_MAX)) begin
         rsp_in.frame_length = wfc_pkg::LEN_W'(wfc_pkg::LEN_OUT_MAX);
      end else begin
         rsp_in.frame_length = wfc_pkg::LEN_W'(frame.length);
      end
      rsp_in.type_total = wfc_pkg::TOTAL_W'(type_next);
      rsp_in.event_total = wfc_pkg::TOTAL_W'(event_next);

      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   // Advance counters on each classified frame
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_mgmt_ff <= '0;
         cnt_ctrl_ff <= '0;
         cnt_data_ff <= '0;
         cnt_eapol_ff <= '0;
         cnt_deauth_ff <= '0;
         cnt_probe_ff <= '0;
      end else if (take) begin
         unique case (ftype)
            wfc_pkg::FTYPE_MGMT: cnt_mgmt_ff <= type_next;
            wfc_pkg::FTYPE_CTRL: cnt_ctrl_ff <= type_next;
            wfc_pkg::FTYPE_DATA: cnt_data_ff <= type_next;
            default: ;
         endcase
         priority if (is_eapol) begin
            cnt_eapol_ff <= event_next;
         end else if (is_deauth_dis) begin
            cnt_deauth_ff <= event_next;
         end else if (is_probe) begin
            cnt_probe_ff <= event_next;
         end
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

>>> src/wifi_frame_classifier.sv
// 802.11 receive-frame classifier. Frame bytes enter one per request on the
// req_ channel, in air order, with last_byte set on the final byte; channel
// and RSSI are taken from the first byte of each frame. One byte is accepted
// every cycle. A frame of at least 24 bytes that ends while sniffing is on
// gives one result on the rsp_ channel, with class (EAPOL, deauth, disassoc,
// probe request, or the plain type), report flag, addresses 1..3, length
// and the running 32-bit totals; shorter frames and frames ending with
// sniffing off give none. A finished result waits in the output register;
// byte intake stalls only when a frame end is pending behind a result that
// has not yet been taken. Registers on the csr_ port: index 0 sniff enable,
// index 1 show data frames; other indexes are ignored. Write them only while
// no frame end is in flight.
module wifi_frame_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  wfc_pkg::req_type                 req,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output wfc_pkg::rsp_type                 rsp,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wfc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wfc_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic               sniff_enable_ff;
   logic               show_data_ff;
   logic               accept;
   logic               take;
   wfc_pkg::frame_type frame;

   // Stall intake only while a frame end cannot move to the output
   assign req_ready = !frame.valid || take;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sniff_enable_ff <= 1'b0;
         show_data_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == wfc_pkg::CSR_SNIFF_ENABLE) begin
            sniff_enable_ff <= csr_data[0];
         end else if (csr_index == wfc_pkg::CSR_SHOW_DATA_FRAMES) begin
            show_data_ff <= csr_data[0];
         end
      end
   end

   wfc_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req),
      .sniff_enable (sniff_enable_ff),
      .take         (take),
      .frame        (frame)
   );

   wfc_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .frame            (frame),
      .show_data_frames (show_data_ff),
      .rsp_ready        (rsp_ready),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp)
   );

endmodule
